/* rtl/core/reacd_pkg.sv */
// package: types and constants for the rotary encoder decoder
package reacd_pkg;

    localparam int NUM_ENCODERS_DEF = 64;

    typedef struct packed {
        logic       kind;
        logic [5:0] encoder_index;
        logic [1:0] pin_pair;
    } t_in_item;

    typedef struct packed {
        logic [5:0]        which_encoder;
        logic signed [7:0] step_count;
        logic [7:0]        speed_timer;
    } t_out_item;

    typedef struct packed {
        logic [1:0] act;
        logic       decinc;
        logic [7:0] count;
        logic [7:0] timer;
        logic [3:0] prev_dec;
        logic [3:0] prev_inc;
        logic [7:0] prev_timer;
        logic [3:0] prediv;
    } t_enc_entry;

    localparam t_enc_entry ENTRY_RESET = t_enc_entry'({2'b11, 37'd0});

    typedef enum logic [1:0] {
        REG_EDGE_MASK    = 2'd0,
        REG_SPEED_MODE   = 2'd1,
        REG_SPEED_AMOUNT = 2'd2,
        REG_SWAP_PINS    = 2'd3
    } t_cfg_reg;

    localparam logic       KIND_READ  = 1'b1;
    localparam logic [1:0] MODE_FAST  = 2'd1;
    localparam logic [1:0] MODE_SLOW  = 2'd2;

    localparam logic [3:0] NIB_INC0 = 4'h2;
    localparam logic [3:0] NIB_INC1 = 4'hb;
    localparam logic [3:0] NIB_INC2 = 4'hd;
    localparam logic [3:0] NIB_INC3 = 4'h4;
    localparam logic [3:0] NIB_DEC0 = 4'h1;
    localparam logic [3:0] NIB_DEC1 = 4'h7;
    localparam logic [3:0] NIB_DEC2 = 4'he;
    localparam logic [3:0] NIB_DEC3 = 4'h8;

    localparam logic [7:0] TIMER_GUARD    = 8'he0;
    localparam logic [7:0] TIMER_RISE_MAX = 8'd20;
    localparam logic [7:0] TIMER_FULL     = 8'hff;
    localparam logic [7:0] FAST_MASK      = 8'hc0;
    localparam logic [7:0] MASK_NONDETENT = 8'hff;
    localparam logic signed [9:0] FAST_LIMIT = 10'sd70;

endpackage

/* rtl/core/rotary_encoder_accel_decoder.sv */
// top level: multi-channel quadrature encoder decoder with acceleration
// Takes one item per clock while o_in_stall is low and returns one result item per
// item, registered in stage 1 and then in the output register. Each item does one
// read-modify-write of its encoder's entry in a table with one write port and one
// registered read port; the entry written by the previous item is forwarded, so items
// for the same encoder may follow back to back. Entries start out at their reset value
// through one valid flop per encoder; no clearing pass is needed. Indexes at or above
// NUM_ENCODERS give count 0 and timer 0.
module rotary_encoder_accel_decoder #(
    parameter int NUM_ENCODERS = reacd_pkg::NUM_ENCODERS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  reacd_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output reacd_pkg::t_out_item  o_out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int AW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

    reacd_pkg::t_enc_entry r_mem [NUM_ENCODERS];

    logic [7:0] r_edge_mask;
    logic [1:0] r_speed_mode;
    logic [2:0] r_speed_amount;
    logic       r_swap_pins;

    logic [NUM_ENCODERS-1:0] r_valid;

    logic                  r_s1_valid;
    reacd_pkg::t_in_item   r_s1_item;
    reacd_pkg::t_enc_entry r_rd_data;
    logic                  r_rd_valid;
    logic                  r_fwd_hit;
    reacd_pkg::t_enc_entry r_fwd_data;

    logic                  r_out_valid;
    reacd_pkg::t_out_item  r_out_item;

    logic                  in_accept;
    logic                  s1_adv;
    logic                  s1_in_range;
    logic [AW-1:0]         in_addr;
    logic [AW-1:0]         wr_addr;
    logic                  wr_en;
    reacd_pkg::t_enc_entry cur;
    reacd_pkg::t_enc_entry wr_entry;
    reacd_pkg::t_out_item  n_out_item;
    logic                  cfg_wr;

    logic [1:0]        pins;
    logic [7:0]        timer1;
    logic [3:0]        nib;
    logic              dec_hit;
    logic              inc_hit;
    logic              dec_ok;
    logic              inc_ok;
    logic              up;
    logic              rise_lim;
    logic [7:0]        t2;
    logic [7:0]        step_fast;
    logic signed [9:0] sum_fast;
    logic [7:0]        cnt_fast;
    logic [3:0]        amt1;
    logic [4:0]        p_sum;
    logic [7:0]        cnt_edge;
    logic [3:0]        prediv_edge;

    assign s1_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !s1_adv;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign in_addr     = AW'(i_in_item.encoder_index);
    assign wr_addr     = AW'(r_s1_item.encoder_index);
    assign s1_in_range = 32'(r_s1_item.encoder_index) < NUM_ENCODERS;
    assign wr_en       = r_s1_valid && s1_adv && s1_in_range;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_mask    <= '0;
            r_speed_mode   <= '0;
            r_speed_amount <= '0;
            r_swap_pins    <= 1'b0;
        end else if (cfg_wr) begin
            case (reacd_pkg::t_cfg_reg'(paddr[3:2]))
                reacd_pkg::REG_EDGE_MASK:    r_edge_mask    <= pwdata[7:0];
                reacd_pkg::REG_SPEED_MODE:   r_speed_mode   <= pwdata[1:0];
                reacd_pkg::REG_SPEED_AMOUNT: r_speed_amount <= pwdata[2:0];
                reacd_pkg::REG_SWAP_PINS:    r_swap_pins    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reacd_pkg::t_cfg_reg'(paddr[3:2]))
            reacd_pkg::REG_EDGE_MASK:    prdata = {24'd0, r_edge_mask};
            reacd_pkg::REG_SPEED_MODE:   prdata = {30'd0, r_speed_mode};
            reacd_pkg::REG_SPEED_AMOUNT: prdata = {29'd0, r_speed_amount};
            reacd_pkg::REG_SWAP_PINS:    prdata = {31'd0, r_swap_pins};
            default:                     prdata = '0;
        endcase
    end

    // entry table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_entry;
        end
        if (in_accept) begin
            r_rd_data <= r_mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // stage 1 control and forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (in_accept) begin
            r_fwd_hit <= wr_en && (wr_addr == in_addr);
        end else if (s1_adv) begin
            r_fwd_hit <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item  <= i_in_item;
            r_rd_valid <= r_valid[in_addr];
            r_fwd_data <= wr_entry;
        end
    end

    // entry update
    always_comb begin
        if (r_fwd_hit) begin
            cur = r_fwd_data;
        end else if (r_rd_valid) begin
            cur = r_rd_data;
        end else begin
            cur = reacd_pkg::ENTRY_RESET;
        end

        pins   = r_swap_pins ? {r_s1_item.pin_pair[0], r_s1_item.pin_pair[1]}
                             : r_s1_item.pin_pair;
        timer1 = (cur.timer != 8'd0) ? cur.timer - 8'd1 : 8'd0;
        nib    = {cur.act, pins};

        dec_hit = (nib == reacd_pkg::NIB_DEC0 && r_edge_mask[4]) ||
                  (nib == reacd_pkg::NIB_DEC1 && r_edge_mask[5]) ||
                  (nib == reacd_pkg::NIB_DEC2 && r_edge_mask[6]) ||
                  (nib == reacd_pkg::NIB_DEC3 && r_edge_mask[7]);
        inc_hit = (nib == reacd_pkg::NIB_INC0 && r_edge_mask[0]) ||
                  (nib == reacd_pkg::NIB_INC1 && r_edge_mask[1]) ||
                  (nib == reacd_pkg::NIB_INC2 && r_edge_mask[2]) ||
                  (nib == reacd_pkg::NIB_INC3 && r_edge_mask[3]);
        dec_ok  = dec_hit && (cur.decinc || timer1 <= reacd_pkg::TIMER_GUARD) &&
                  (r_edge_mask != reacd_pkg::MASK_NONDETENT || nib != cur.prev_dec);
        inc_ok  = !dec_hit && inc_hit &&
                  (!cur.decinc || timer1 <= reacd_pkg::TIMER_GUARD) &&
                  (r_edge_mask != reacd_pkg::MASK_NONDETENT || nib != cur.prev_inc);
        up      = inc_ok;

        // acceleration rise limit
        rise_lim = {1'b0, timer1} > ({1'b0, cur.prev_timer} + {1'b0, reacd_pkg::TIMER_RISE_MAX});
        t2       = rise_lim ? cur.prev_timer + reacd_pkg::TIMER_RISE_MAX : timer1;

        step_fast = (t2 & reacd_pkg::FAST_MASK) >> (3'd7 - r_speed_amount);
        if (step_fast == 8'd0) begin
            step_fast = 8'd1;
        end
        if (up) begin
            sum_fast = {{2{cur.count[7]}}, cur.count} + {2'b00, step_fast};
            if (sum_fast > reacd_pkg::FAST_LIMIT) begin
                sum_fast = reacd_pkg::FAST_LIMIT;
            end
        end else begin
            sum_fast = {{2{cur.count[7]}}, cur.count} - {2'b00, step_fast};
            if (sum_fast < -reacd_pkg::FAST_LIMIT) begin
                sum_fast = -reacd_pkg::FAST_LIMIT;
            end
        end
        cnt_fast = sum_fast[7:0];

        // slow mode predivider, bit 4 flags the wrap either way
        amt1  = {1'b0, r_speed_amount} + 4'd1;
        p_sum = up ? {1'b0, cur.prediv} + {1'b0, amt1} : {1'b0, cur.prediv} - {1'b0, amt1};

        prediv_edge = cur.prediv;
        case (r_speed_mode)
            reacd_pkg::MODE_FAST: begin
                cnt_edge = cnt_fast;
            end
            reacd_pkg::MODE_SLOW: begin
                prediv_edge = p_sum[3:0];
                if (p_sum[4]) begin
                    cnt_edge = up ? cur.count + 8'd1 : cur.count - 8'd1;
                end else begin
                    cnt_edge = cur.count;
                end
            end
            default: begin
                cnt_edge = up ? cur.count + 8'd1 : cur.count - 8'd1;
            end
        endcase

        wr_entry = cur;
        if (r_s1_item.kind == reacd_pkg::KIND_READ) begin
            wr_entry.count = 8'd0;
        end else if (r_edge_mask != 8'd0) begin
            wr_entry.timer = timer1;
            wr_entry.act   = pins;
            if (dec_ok || inc_ok) begin
                wr_entry.decinc     = dec_ok;
                wr_entry.count      = cnt_edge;
                wr_entry.prediv     = prediv_edge;
                wr_entry.prev_timer = t2;
                wr_entry.timer      = reacd_pkg::TIMER_FULL;
                if (up) begin
                    wr_entry.prev_inc = nib;
                end else begin
                    wr_entry.prev_dec = nib;
                end
            end
        end

        n_out_item.which_encoder = r_s1_item.encoder_index;
        if (!s1_in_range) begin
            n_out_item.step_count  = '0;
            n_out_item.speed_timer = '0;
        end else if (r_s1_item.kind == reacd_pkg::KIND_READ) begin
            n_out_item.step_count  = cur.count;
            n_out_item.speed_timer = cur.timer;
        end else begin
            n_out_item.step_count  = wr_entry.count;
            n_out_item.speed_timer = wr_entry.timer;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_out_item <= n_out_item;
        end
    end

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (32'(o_out_item.which_encoder) >= NUM_ENCODERS) |->
            o_out_item.step_count == '0 && o_out_item.speed_timer == '0)
        else $error("out-of-range item reported nonzero state");

    a_no_wr_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !(r_out_valid && i_out_stall))
        else $error("entry written back while result is blocked");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled with empty stage");

    a_fwd_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_s1_valid)
        else $error("forward flag set without an item in stage");

endmodule
